>>> sv/erm_pkg.sv
`timescale 1ns / 1ps
// erm_pkg: types, constants and helper functions for the Euler rotation matrix block.
// No dependencies.
package erm_pkg;

	localparam int ANGLE_BITS  = 16;
	localparam int TRIG_STAGES = 16;
	localparam int CW          = 33;
	localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30  = 33'sd1073741824;

	typedef struct packed {
		logic signed [15:0] angle_theta;
		logic signed [15:0] angle_phi;
		logic signed [15:0] angle_alpha;
	} erm_in_t;

	typedef struct packed {
		logic signed [15:0] e0;
		logic signed [15:0] e1;
		logic signed [15:0] e2;
		logic signed [15:0] e3;
		logic signed [15:0] e4;
		logic signed [15:0] e5;
		logic signed [15:0] e6;
		logic signed [15:0] e7;
		logic signed [15:0] e8;
	} erm_out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [1:0]           quad;
	} erm_cord_t;

	typedef struct packed {
		erm_cord_t t;
		erm_cord_t p;
		erm_cord_t a;
	} erm_trio_t;

	// atan(2^-i), 2^32 units per turn
	function automatic logic signed [CW-1:0] erm_atan(input logic [4:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0:  r = 33'sd536870912;
			5'd1:  r = 33'sd316933406;
			5'd2:  r = 33'sd167458907;
			5'd3:  r = 33'sd85004756;
			5'd4:  r = 33'sd42667331;
			5'd5:  r = 33'sd21354465;
			5'd6:  r = 33'sd10679838;
			5'd7:  r = 33'sd5340245;
			5'd8:  r = 33'sd2670163;
			5'd9:  r = 33'sd1335087;
			5'd10: r = 33'sd667544;
			5'd11: r = 33'sd333772;
			5'd12: r = 33'sd166886;
			5'd13: r = 33'sd83443;
			5'd14: r = 33'sd41722;
			5'd15: r = 33'sd20861;
			5'd16: r = 33'sd10430;
			5'd17: r = 33'sd5215;
			5'd18: r = 33'sd2608;
			5'd19: r = 33'sd1304;
			5'd20: r = 33'sd652;
			5'd21: r = 33'sd326;
			5'd22: r = 33'sd163;
			5'd23: r = 33'sd81;
			5'd24: r = 33'sd41;
			5'd25: r = 33'sd20;
			5'd26: r = 33'sd10;
			5'd27: r = 33'sd5;
			5'd28: r = 33'sd3;
			5'd29: r = 33'sd1;
			5'd30: r = 33'sd1;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

	function automatic erm_cord_t erm_init(input logic [15:0] ang);
		logic [31:0] ext;
		logic [31:0] ph;
		erm_cord_t   c;
		ext    = {{16{ang[15]}}, ang};
		ph     = 32'(ext << (32 - ANGLE_BITS));
		c.x    = GAIN_Q30;
		c.y    = '0;
		c.z    = CW'({2'b00, ph[29:0]});
		c.quad = ph[31:30];
		return c;
	endfunction

	function automatic logic signed [31:0] erm_clamp30(input logic signed [CW-1:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30)       r = 32'sd1073741824;
		else if (v < -ONE_Q30) r = -32'sd1073741824;
		else                   r = 32'(v);
		return r;
	endfunction

	function automatic logic signed [15:0] erm_sat14(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd16384)       r = 16'sd16384;
		else if (v < -64'sd16384) r = -16'sd16384;
		else                      r = 16'(v);
		return r;
	endfunction

endpackage

>>> sv/erm_cell.sv
`timescale 1ns / 1ps
// erm_cell: one CORDIC rotation step for the three angles, registered.
// Depends on erm_pkg.
module erm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        idx,
	input  logic              vld,
	input  erm_pkg::erm_trio_t d,
	output logic              vld_q,
	output erm_pkg::erm_trio_t d_q
);
	import erm_pkg::*;

	function automatic erm_cord_t step(input erm_cord_t c, input logic [4:0] i);
		erm_cord_t         r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r.quad = c.quad;
		if (c.z >= 0) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - erm_atan(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + erm_atan(i);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else         vld_q <= vld;
	end

	always_ff @(posedge clk) begin
		d_q.t <= step(d.t, idx);
		d_q.p <= step(d.p, idx);
		d_q.a <= step(d.a, idx);
	end
endmodule

>>> sv/erm_mix.sv
`timescale 1ns / 1ps
// erm_mix: quadrant fold, products and rounding into the nine matrix entries.
// Depends on erm_pkg.
module erm_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  erm_pkg::erm_trio_t d,
	output logic              done,
	output erm_pkg::erm_out_t result
);
	import erm_pkg::*;

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [31:0] st_s1, ct_s1, sp_s1, cp_s1, sa_s1, ca_s1;
	logic signed [31:0] st_s2, ct_s2, sp_s2, cp_s2, sa_s2, ca_s2, sast_s2, cast_s2;
	logic signed [63:0] ctcp_s3, ctsp_s3, sastcp_s3, casp_s3, sastsp_s3, cacp_s3;
	logic signed [63:0] sact_s3, castcp_s3, sasp_s3, castsp_s3, sacp_s3, cact_s3;
	logic signed [15:0] e2_s3;
	logic signed [63:0] sast_w, cast_w, nst_w;

	function automatic logic signed [63:0] fold(input erm_cord_t c, input logic want_sin);
		logic signed [31:0] cc, ss, ro, rs;
		cc = erm_clamp30(c.x);
		ss = erm_clamp30(c.y);
		case (c.quad)
			2'd0:    begin ro = cc;  rs = ss;  end
			2'd1:    begin ro = -ss; rs = cc;  end
			2'd2:    begin ro = -cc; rs = -ss; end
			default: begin ro = ss;  rs = -cc; end
		endcase
		return want_sin ? 64'(rs) : 64'(ro);
	endfunction

	function automatic logic signed [63:0] mul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return 64'(a) * 64'(b);
	endfunction

	function automatic logic signed [15:0] rnd60(input logic signed [63:0] v);
		return erm_sat14((v + 64'sd35184372088832) >>> 46);
	endfunction

	assign sast_w = (mul(sa_s1, st_s1) + 64'sd536870912) >>> 30;
	assign cast_w = (mul(ca_s1, st_s1) + 64'sd536870912) >>> 30;
	assign nst_w  = (-64'(st_s2) + 64'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		st_s1 <= 32'(fold(d.t, 1'b1));
		ct_s1 <= 32'(fold(d.t, 1'b0));
		sp_s1 <= 32'(fold(d.p, 1'b1));
		cp_s1 <= 32'(fold(d.p, 1'b0));
		sa_s1 <= 32'(fold(d.a, 1'b1));
		ca_s1 <= 32'(fold(d.a, 1'b0));

		st_s2   <= st_s1;
		ct_s2   <= ct_s1;
		sp_s2   <= sp_s1;
		cp_s2   <= cp_s1;
		sa_s2   <= sa_s1;
		ca_s2   <= ca_s1;
		sast_s2 <= 32'(sast_w);
		cast_s2 <= 32'(cast_w);

		ctcp_s3   <= mul(ct_s2, cp_s2);
		ctsp_s3   <= mul(ct_s2, sp_s2);
		sastcp_s3 <= mul(sast_s2, cp_s2);
		casp_s3   <= mul(ca_s2, sp_s2);
		sastsp_s3 <= mul(sast_s2, sp_s2);
		cacp_s3   <= mul(ca_s2, cp_s2);
		sact_s3   <= mul(sa_s2, ct_s2);
		castcp_s3 <= mul(cast_s2, cp_s2);
		sasp_s3   <= mul(sa_s2, sp_s2);
		castsp_s3 <= mul(cast_s2, sp_s2);
		sacp_s3   <= mul(sa_s2, cp_s2);
		cact_s3   <= mul(ca_s2, ct_s2);
		e2_s3     <= erm_sat14(nst_w);

		result.e0 <= rnd60(ctcp_s3);
		result.e1 <= rnd60(ctsp_s3);
		result.e2 <= e2_s3;
		result.e3 <= rnd60(sastcp_s3 - casp_s3);
		result.e4 <= rnd60(sastsp_s3 + cacp_s3);
		result.e5 <= rnd60(sact_s3);
		result.e6 <= rnd60(castcp_s3 + sasp_s3);
		result.e7 <= rnd60(castsp_s3 - sacp_s3);
		result.e8 <= rnd60(cact_s3);
	end
endmodule

>>> sv/euler_rotation_matrix.sv
`timescale 1ns / 1ps
// Throughput: one transfer per cycle; the chain of CORDIC cells and the
// product pipeline each take a new angle triple every clock. busy is never high.
// Reset clears only the valid bits of the pipeline; no result appears after reset
// until a start is taken. The receiver cannot stall: done lasts one cycle.
// Depends on erm_pkg, erm_cell, erm_mix.
module euler_rotation_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  erm_pkg::erm_in_t  args,
	output logic              done,
	output erm_pkg::erm_out_t result
);
	import erm_pkg::*;

	erm_trio_t chain [TRIG_STAGES+1];
	logic      vchain [TRIG_STAGES+1];

	assign busy      = 1'b0;
	assign vchain[0] = start;
	assign chain[0].t = erm_init(args.angle_theta);
	assign chain[0].p = erm_init(args.angle_phi);
	assign chain[0].a = erm_init(args.angle_alpha);

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
		erm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (5'(i)),
			.vld    (vchain[i]),
			.d      (chain[i]),
			.vld_q  (vchain[i+1]),
			.d_q    (chain[i+1])
		);
	end

	erm_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vchain[TRIG_STAGES]),
		.d      (chain[TRIG_STAGES]),
		.done   (done),
		.result (result)
	);
endmodule

>>> test/erm_checker.sv
`timescale 1ns / 1ps
// erm_checker: watches the angle and matrix transfers of euler_rotation_matrix,
// predicts each matrix in fixed point and compares the whole matrix. Depends on erm_pkg.
module erm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  erm_pkg::erm_in_t  args,
	input  logic              done,
	input  erm_pkg::erm_out_t result,
	output int                fail_count,
	output int                pending
);
	import erm_pkg::*;

	erm_out_t matrix_q[$];

	localparam longint ONE30 = 64'sd1073741824;
	localparam longint GAIN30 = 64'sd652032874;

	function automatic longint lim(input longint v, input longint l);
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

	function automatic void trig(input logic [15:0] ang, output longint s, output longint c);
		longint x, y, z, dx, dy, cc, ss;
		logic [31:0] ph;
		logic [1:0] q;
		x = GAIN30;
		y = 0;
		ph = 32'({{16{ang[15]}}, ang} << (32 - ANGLE_BITS));
		q = ph[31:30];
		z = longint'(ph[29:0]);
		for (int i = 0; i < TRIG_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= erm_atan(5'(i));
			end else begin
				x += dx; y -= dy; z += erm_atan(5'(i));
			end
		end
		cc = lim(x, ONE30);
		ss = lim(y, ONE30);
		case (q)
			2'd0: begin c = cc; s = ss; end
			2'd1: begin c = -ss; s = cc; end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endfunction

	function automatic logic [15:0] q60(input longint v);
		return 16'(lim((v + (64'sd1 <<< 45)) >>> 46, 16384));
	endfunction

	function automatic erm_out_t rotation(input erm_in_t a);
		longint st, ct, sp, cp, sa, ca, sast, cast;
		erm_out_t r;
		trig(a.angle_theta, st, ct);
		trig(a.angle_phi, sp, cp);
		trig(a.angle_alpha, sa, ca);
		sast = (sa * st + (64'sd1 <<< 29)) >>> 30;
		cast = (ca * st + (64'sd1 <<< 29)) >>> 30;
		r.e0 = q60(ct * cp);
		r.e1 = q60(ct * sp);
		r.e2 = 16'(lim((-st + 64'sd32768) >>> 16, 16384));
		r.e3 = q60(sast * cp - ca * sp);
		r.e4 = q60(sast * sp + ca * cp);
		r.e5 = q60(sa * ct);
		r.e6 = q60(cast * cp + sa * sp);
		r.e7 = q60(cast * sp - sa * cp);
		r.e8 = q60(ca * ct);
		return r;
	endfunction

	assign pending = matrix_q.size();

	always @(posedge clk or negedge arst_n) begin
		erm_out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				matrix_q.push_back(rotation(args));
			if (done) begin
				if (matrix_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected matrix %h", result);
					fail_count <= fail_count + 1;
				end else begin
					want = matrix_q.pop_front();
					if (want !== result) begin
						if (fail_count < 10)
							$display("matrix mismatch: exp %h got %h", want, result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives angle triples into euler_rotation_matrix with random gaps (none in a
// stretch of the random run) and gives the verdict. Depends on erm_pkg, euler_rotation_matrix and erm_checker.
module tb_top;
	import erm_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	erm_in_t args = '0;
	erm_out_t result;
	int fail_count, pending;
	int idle_run = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	euler_rotation_matrix i_dut (.clk, .arst_n, .start, .busy, .args, .done, .result);
	erm_checker i_chk (.clk, .arst_n, .start, .busy, .args, .done, .result,
		.fail_count, .pending);

	always @(posedge clk) begin
		if (start && !busy) idle_run <= 0;
		else idle_run <= idle_run + 1;
		if (idle_run > 2000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(input logic [15:0] t, input logic [15:0] p, input logic [15:0] a,
			input bit gaps);
		while (gaps && $urandom_range(99) < 23) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		args <= '{t, p, a};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_angle();
		logic [15:0] corner [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'h7FFF, 16'hFFFF, 16'h0001, 16'h3FFF};
		if ($urandom_range(9) == 0) return corner[$urandom_range(7)];
		return 16'($urandom);
	endfunction

	initial begin
		logic [15:0] dir [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
			16'h8001, 16'hFFFF, 16'h0001, 16'h2000, 16'h3FFF, 16'h5555, 16'hAAAA};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir[i])
			send(dir[i], dir[(i + 3) % 12], dir[(i + 7) % 12], 1);
		send(16'h7FFF, 16'h8000, 16'hFFFF, 1);
		send(16'h8000, 16'h7FFF, 16'h0000, 1);
		for (int n = 0; n < 1000; n++)
			send(pick_angle(), pick_angle(), pick_angle(), !(n >= 300 && n < 500));
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
